// ===== rtl/mcle_pkg.sv =====
`timescale 1ns / 1ps
package mcle_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned SensorW    = 6;
  localparam int unsigned LineW      = 42;   // p1 +- quotient saturated at 2^40
  localparam int unsigned QuotSatExp = 40;
  localparam int unsigned MaxCreated = 63;
  localparam int unsigned OutCntW    = 6;

  // input op codes
  localparam logic OP_HIT = 1'b0;
  localparam logic OP_END = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PASS    = 2'd0;
  localparam logic [1:0] KIND_CREATED = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_REF_A    = 3'd0;
  localparam logic [2:0] REG_REF_B    = 3'd1;
  localparam logic [2:0] REG_DUT_MASK = 3'd2;
  localparam logic [2:0] REG_AXIS     = 3'd3;
  localparam logic [2:0] REG_MAX_RES  = 3'd4;
  localparam logic [2:0] REG_MULTI    = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] p1;
    logic signed [CoordW-1:0] p2;
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] z1;
    logic signed [CoordW-1:0] z2;
  } line_req_t;

endpackage

// ===== rtl/missing_coordinate_line_estimator_core.sv =====
`timescale 1ns / 1ps
// Straight-line estimator for the missing coordinate on strip planes.
// Input stream: tuser = op (0 hit, 1 end of event); tdata = sensor, x, y, z.
// Hits on the two reference planes and on planes flagged in dut_plane_mask
// are written to on-chip stores; a hit not on a strip plane is copied to the
// output as a kind 0 item with tlast set. A hit is taken only while the
// output register is free; when both reference ids are equal, its b copy
// is written later from a pending register (the store has one write port).
// End of event: every stored strip hit is checked against every pair of
// reference hits. Each pair takes two line evaluations on one shared unit,
// each a registered 33x33 multiply and a 66-step serial divide; a pair with
// equal z is skipped without evaluation.
// Created hits leave as kind 1 items, then one kind 2 status item with tlast.
// No new item is taken until that status item is in the output register.
// A stalled receiver holds the output register and the search waits on it.
// Reset clears counts, flags, state and loads register defaults; the stores
// themselves are not cleared.
module missing_coordinate_line_estimator_core #(
  parameter int unsigned REF_HITS = 8,
  parameter int unsigned DUT_HITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,   // sensor_id, pos_x, pos_y, pos_z, zero fill
  input  logic          s_axis_tuser,   // op
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // out_sensor, out_x, out_y, out_z,
                                        // hits_dropped, no_reference
  output logic [1:0]    m_axis_tuser,   // kind
  output logic          m_axis_tlast,   // last
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_addr_i,
  input  logic [63:0]   cfg_data_i
);
  import mcle_pkg::*;

  localparam int unsigned RAW = (REF_HITS > 1) ? $clog2(REF_HITS) : 1;
  localparam int unsigned DAW = (DUT_HITS > 1) ? $clog2(DUT_HITS) : 1;
  localparam int unsigned RCW = $clog2(REF_HITS + 1);
  localparam int unsigned DCW = $clog2(DUT_HITS + 1);
  localparam int unsigned RefW = 3 * CoordW;
  localparam int unsigned DutW = SensorW + 3 * CoordW;

  typedef enum logic [3:0] {
    S_IDLE, S_DUT, S_DUTW, S_PAIR, S_PAIRW, S_KNOWN, S_EST, S_EVAL,
    S_DUTEND, S_EMIT, S_STAT
  } state_e;

  // configuration
  logic [SensorW-1:0] ref_a_q, ref_b_q;
  logic [63:0]        dut_mask_q;
  logic               axis_q, multi_q;
  logic [30:0]        max_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_a_q    <= SensorW'(0);
      ref_b_q    <= SensorW'(1);
      dut_mask_q <= '0;
      axis_q     <= 1'b0;
      max_res_q  <= 31'd10240;
      multi_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_REF_A:    ref_a_q    <= cfg_data_i[SensorW-1:0];
        REG_REF_B:    ref_b_q    <= cfg_data_i[SensorW-1:0];
        REG_DUT_MASK: dut_mask_q <= cfg_data_i;
        REG_AXIS:     axis_q     <= cfg_data_i[0];
        REG_MAX_RES:  max_res_q  <= cfg_data_i[30:0];
        REG_MULTI:    multi_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [SensorW-1:0] in_s;
  logic [RefW-1:0]    in_xyz;
  assign in_s   = s_axis_tdata[5:0];
  assign in_xyz = {s_axis_tdata[101:70], s_axis_tdata[69:38], s_axis_tdata[37:6]};

  // stores: reference a in the low half, reference b in the high half
  logic [RefW-1:0] ref_mem [2**(RAW+1)];
  logic [DutW-1:0] dut_mem [2**DAW];
  logic            ref_we, dut_we;
  logic [RAW:0]    ref_waddr;
  logic [RefW-1:0] ref_wdata;
  logic [RefW-1:0] ra_q, rb_q;
  logic [DutW-1:0] dq_q;

  state_e           state_q;
  logic [RCW-1:0]   cnta_q, cntb_q, i_q, j_q;
  logic [DCW-1:0]   cntd_q, d_q;
  logic             ovf_q, drop_q, found_q;
  logic             pend_q;
  logic [RAW-1:0]   pend_idx_q;
  logic [RefW-1:0]  pend_data_q;
  logic [OutCntW-1:0] n_q;
  logic [42:0]      best_q;
  logic signed [LineW-1:0] best_est_q, kk_q, est_q, emit_est_q;
  state_e           emit_ret_q;
  logic [SensorW-1:0] ds_q;
  logic signed [CoordW-1:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (dut_we) dut_mem[cntd_q[DAW-1:0]] <= {in_xyz, in_s};
    ra_q <= ref_mem[{1'b0, i_q[RAW-1:0]}];
    rb_q <= ref_mem[{1'b1, j_q[RAW-1:0]}];
    dq_q <= dut_mem[d_q[DAW-1:0]];
  end

  // output register
  logic               out_vld_q, out_free, out_load;
  logic [1:0]         out_kind_q, out_kind_d;
  logic [SensorW-1:0] out_s_q, out_s_d;
  logic [CoordW-1:0]  out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic               out_drop_q, out_drop_d, out_noref_q, out_noref_d;
  logic               out_last_q, out_last_d;

  assign out_free = !out_vld_q || m_axis_tready;

  // hit handling
  logic in_acc, hit_acc, end_acc, hit_a, hit_b, hit_d, a_ok, b_ok, d_ok;
  assign s_axis_tready = (state_q == S_IDLE) && !pend_q && out_free;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign hit_acc = in_acc && (s_axis_tuser == OP_HIT);
  assign end_acc = in_acc && (s_axis_tuser == OP_END);
  assign hit_a   = in_s == ref_a_q;
  assign hit_b   = in_s == ref_b_q;
  assign hit_d   = dut_mask_q[in_s];
  assign a_ok    = hit_a && (cnta_q < RCW'(REF_HITS));
  assign b_ok    = hit_b && (cntb_q < RCW'(REF_HITS));
  assign d_ok    = hit_d && (cntd_q < DCW'(DUT_HITS));
  assign dut_we  = hit_acc && d_ok;

  always_comb begin
    ref_we    = pend_q || (hit_acc && (a_ok || b_ok));
    ref_waddr = {1'b1, cntb_q[RAW-1:0]};
    ref_wdata = in_xyz;
    if (pend_q) begin
      ref_waddr = {1'b1, pend_idx_q};
      ref_wdata = pend_data_q;
    end else if (a_ok) begin
      ref_waddr = {1'b0, cnta_q[RAW-1:0]};
    end
  end

  // line evaluation
  line_req_t ln_req;
  logic      ln_start, ln_done, sel_est;
  logic signed [LineW-1:0] ln_res;
  logic signed [CoordW-1:0] ax, ay, az, bx, by, bz, known;

  assign {az, ay, ax} = ra_q;
  assign {bz, by, bx} = rb_q;
  assign sel_est = (state_q == S_KNOWN);
  assign known   = axis_q ? dx_q : dy_q;
  always_comb begin
    if (axis_q ^ sel_est) begin
      ln_req.p1 = ax;
      ln_req.p2 = bx;
    end else begin
      ln_req.p1 = ay;
      ln_req.p2 = by;
    end
    ln_req.z  = dz_q;
    ln_req.z1 = az;
    ln_req.z2 = bz;
  end
  assign ln_start = ((state_q == S_PAIRW) && (az != bz)) || ((state_q == S_KNOWN) && ln_done);

  mcle_line u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ln_start),
    .req_i   (ln_req),
    .done_o  (ln_done),
    .res_o   (ln_res)
  );

  logic signed [42:0] diff;
  logic [42:0]        resid;
  logic               pass, last_j;
  assign diff   = 43'(kk_q) - 43'(known);
  assign resid  = diff[42] ? 43'(-diff) : diff;
  assign pass   = resid < 43'(max_res_q);
  assign last_j = (j_q + 1'b1) == cntb_q;

  // saturated estimate
  logic [CoordW-1:0] est32;
  always_comb begin
    if (emit_est_q[LineW-1:CoordW-1] == '0 || emit_est_q[LineW-1:CoordW-1] == '1)
      est32 = emit_est_q[CoordW-1:0];
    else if (emit_est_q[LineW-1])
      est32 = {1'b1, {(CoordW-1){1'b0}}};
    else
      est32 = {1'b0, {(CoordW-1){1'b1}}};
  end

  always_comb begin
    out_load    = 1'b0;
    out_kind_d  = KIND_PASS;
    out_s_d     = in_s;
    out_x_d     = s_axis_tdata[37:6];
    out_y_d     = s_axis_tdata[69:38];
    out_z_d     = s_axis_tdata[101:70];
    out_drop_d  = 1'b0;
    out_noref_d = 1'b0;
    out_last_d  = 1'b1;
    if (hit_acc && !hit_d) begin
      out_load = 1'b1;
    end else if (state_q == S_EMIT && n_q < OutCntW'(MaxCreated) && out_free) begin
      out_load   = 1'b1;
      out_kind_d = KIND_CREATED;
      out_s_d    = ds_q;
      out_x_d    = axis_q ? dx_q : est32;
      out_y_d    = axis_q ? est32 : dy_q;
      out_z_d    = dz_q;
      out_last_d = 1'b0;
    end else if (state_q == S_STAT && out_free) begin
      out_load    = 1'b1;
      out_kind_d  = KIND_STATUS;
      out_s_d     = '0;
      out_x_d     = '0;
      out_y_d     = '0;
      out_z_d     = '0;
      out_drop_d  = drop_q;
      out_noref_d = (cnta_q == '0) || (cntb_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_load || (out_vld_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_s_q     <= out_s_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_z_q     <= out_z_d;
      out_drop_q  <= out_drop_d;
      out_noref_q <= out_noref_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_noref_q, out_drop_q, out_z_q, out_y_q, out_x_q, out_s_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnta_q     <= '0;
      cntb_q     <= '0;
      cntd_q     <= '0;
      ovf_q      <= 1'b0;
      pend_q     <= 1'b0;
      drop_q     <= 1'b0;
      found_q    <= 1'b0;
      n_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      d_q        <= '0;
      emit_ret_q <= S_IDLE;
    end else begin
      pend_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (hit_acc) begin
            if (a_ok) cnta_q <= cnta_q + 1'b1;
            if (b_ok) cntb_q <= cntb_q + 1'b1;
            if (d_ok) cntd_q <= cntd_q + 1'b1;
            if (a_ok && b_ok) begin
              pend_q      <= 1'b1;
              pend_idx_q  <= cntb_q[RAW-1:0];
              pend_data_q <= in_xyz;
            end
            if ((hit_a && !a_ok) || (hit_b && !b_ok) || (hit_d && !d_ok)) ovf_q <= 1'b1;
          end else if (end_acc) begin
            d_q     <= '0;
            n_q     <= '0;
            drop_q  <= ovf_q;
            state_q <= S_DUT;
          end
        end
        S_DUT: state_q <= (d_q == cntd_q) ? S_STAT : S_DUTW;
        S_DUTW: begin
          {dz_q, dy_q, dx_q, ds_q} <= dq_q;
          i_q     <= '0;
          j_q     <= '0;
          found_q <= 1'b0;
          state_q <= S_PAIR;
        end
        S_PAIR: state_q <= (i_q == cnta_q || cntb_q == '0) ? S_DUTEND : S_PAIRW;
        S_PAIRW: begin
          if (az == bz) begin
            j_q     <= last_j ? '0 : j_q + 1'b1;
            i_q     <= last_j ? i_q + 1'b1 : i_q;
            state_q <= S_PAIR;
          end else begin
            state_q <= S_KNOWN;
          end
        end
        S_KNOWN: begin
          if (ln_done) begin
            kk_q    <= ln_res;
            state_q <= S_EST;
          end
        end
        S_EST: begin
          if (ln_done) begin
            est_q   <= ln_res;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          j_q     <= last_j ? '0 : j_q + 1'b1;
          i_q     <= last_j ? i_q + 1'b1 : i_q;
          state_q <= S_PAIR;
          if (pass) begin
            if (multi_q) begin
              emit_est_q <= est_q;
              emit_ret_q <= S_PAIR;
              state_q    <= S_EMIT;
            end else if (!found_q || resid < best_q) begin
              found_q    <= 1'b1;
              best_q     <= resid;
              best_est_q <= est_q;
            end
          end
        end
        S_DUTEND: begin
          d_q     <= d_q + 1'b1;
          state_q <= S_DUT;
          if (!multi_q && found_q) begin
            emit_est_q <= best_est_q;
            emit_ret_q <= S_DUT;
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (n_q >= OutCntW'(MaxCreated)) begin
            drop_q  <= 1'b1;
            state_q <= emit_ret_q;
          end else if (out_free) begin
            n_q     <= n_q + 1'b1;
            state_q <= emit_ret_q;
          end
        end
        S_STAT: begin
          if (out_free) begin
            cnta_q  <= '0;
            cntb_q  <= '0;
            cntd_q  <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mcle_line.sv =====
`timescale 1ns / 1ps
// p1 + trunc((p2-p1)*(z-z1)/(z2-z1)), one multiply then a bit-serial divide.
module mcle_line (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  mcle_pkg::line_req_t               req_i,
  output logic                              done_o,
  output logic signed [mcle_pkg::LineW-1:0] res_o
);
  import mcle_pkg::*;

  localparam int unsigned MagW = CoordW + 1;
  localparam int unsigned NumW = 2 * MagW;
  localparam int unsigned CntW = $clog2(NumW);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lstate_e;

  lstate_e             state_q;
  logic [MagW-1:0]     mdp_q, mdz_q, mden_q;
  logic                neg_q;
  logic signed [CoordW-1:0] p1_q;
  logic [NumW-1:0]     num_q;
  logic [MagW-1:0]     rem_q;
  logic [CntW-1:0]     cnt_q;
  logic                done_q;
  logic signed [LineW-1:0] res_q;

  logic signed [MagW-1:0] dp, dz, den;
  logic [MagW:0]       rem_sh;
  logic                qbit;
  logic [MagW:0]       rem_sub;
  logic [QuotSatExp:0] qsat;
  logic signed [LineW-1:0] p1_ext, q_ext;

  assign dp  = MagW'(req_i.p2) - MagW'(req_i.p1);
  assign dz  = MagW'(req_i.z)  - MagW'(req_i.z1);
  assign den = MagW'(req_i.z2) - MagW'(req_i.z1);

  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign qbit    = rem_sh >= {1'b0, mden_q};
  assign rem_sub = rem_sh - {1'b0, mden_q};

  assign qsat   = (num_q > NumW'(64'd1 << QuotSatExp)) ? (QuotSatExp+1)'(64'd1 << QuotSatExp)
                                                      : num_q[QuotSatExp:0];
  assign p1_ext = LineW'(p1_q);
  assign q_ext  = $signed(LineW'(qsat));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            mdp_q   <= dp[MagW-1]  ? MagW'(-dp)  : dp;
            mdz_q   <= dz[MagW-1]  ? MagW'(-dz)  : dz;
            mden_q  <= den[MagW-1] ? MagW'(-den) : den;
            neg_q   <= dp[MagW-1] ^ dz[MagW-1] ^ den[MagW-1];
            p1_q    <= req_i.p1;
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          num_q   <= mdp_q * mdz_q;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= L_DIV;
        end
        L_DIV: begin
          rem_q <= qbit ? rem_sub[MagW-1:0] : rem_sh[MagW-1:0];
          num_q <= {num_q[NumW-2:0], qbit};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(NumW - 1)) state_q <= L_FIN;
        end
        L_FIN: begin
          res_q   <= neg_q ? (p1_ext - q_ext) : (p1_ext + q_ext);
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/mcle_checker.sv =====
`timescale 1ns / 1ps
module mcle_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import mcle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item withdrawn while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tlast)
    else $error("status item without tlast");

  a_created_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_CREATED |-> !m_axis_tlast)
    else $error("created item with tlast");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tdata[101:0] == '0)
    else $error("status item carries hit data");

  a_hit_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_PASS || m_axis_tuser == KIND_CREATED)
      |-> m_axis_tdata[103:102] == 2'b00)
    else $error("status flags set on hit item");

endmodule

bind missing_coordinate_line_estimator_core mcle_checker u_mcle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import mcle_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned StoreDepth = 8;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  sensor;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        dropped;
    logic        no_ref;
    logic        last;
  } hit_out_t;

  // Straight-line predictor plus a queue of expected output items.
  class track_scoreboard;
    bit [5:0]  plane_a = 0;
    bit [5:0]  plane_b = 1;
    bit [63:0] strip_mask = 0;
    bit        est_y = 0;
    bit [30:0] res_limit = 10240;
    bit        multi = 1;
    longint    ax[$], ay[$], az[$], bx[$], by[$], bz[$];
    longint    sx[$], sy[$], sz[$];
    bit [5:0]  sid[$];
    bit        lost;
    hit_out_t  expq[$];
    int        errors;

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_REF_A:    plane_a = v[5:0];
        REG_REF_B:    plane_b = v[5:0];
        REG_DUT_MASK: strip_mask = v;
        REG_AXIS:     est_y = v[0];
        REG_MAX_RES:  res_limit = v[30:0];
        REG_MULTI:    multi = v[0];
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // p1 + trunc((p2-p1)*(z-z1)/(z2-z1)); 64-bit product wraps, quotient saturates
    function longint line_at(longint p1, longint p2, longint zz, longint z1, longint z2);
      longint dp, dz, den;
      longint unsigned q;
      bit neg;
      dp = p2 - p1; dz = zz - z1; den = z2 - z1;
      neg = (dp < 0) ^ (dz < 0) ^ (den < 0);
      q = (mag(dp) * mag(dz)) / mag(den);
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return neg ? p1 - longint'(q) : p1 + longint'(q);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void push_created(int d, longint est, ref int n);
      hit_out_t e;
      longint x, y;
      if (n >= MaxCreated) begin
        lost = 1;
        return;
      end
      x = sx[d]; y = sy[d];
      if (est_y) y = sat32(est); else x = sat32(est);
      e = '{KIND_CREATED, sid[d], x[31:0], y[31:0], sz[d][31:0], 1'b0, 1'b0, 1'b0};
      expq.insert(expq.size(), e);
      n++;
    endfunction

    function void close_event();
      int n;
      longint known, kk, est, best_est;
      longint unsigned r, best;
      bit found;
      hit_out_t e;
      n = 0;
      for (int d = 0; d < sz.size(); d++) begin
        found = 0; best = 0; best_est = 0;
        known = est_y ? sx[d] : sy[d];
        for (int i = 0; i < az.size(); i++) begin
          for (int j = 0; j < bz.size(); j++) begin
            if (az[i] == bz[j]) continue;
            if (est_y) begin
              kk  = line_at(ax[i], bx[j], sz[d], az[i], bz[j]);
              est = line_at(ay[i], by[j], sz[d], az[i], bz[j]);
            end else begin
              kk  = line_at(ay[i], by[j], sz[d], az[i], bz[j]);
              est = line_at(ax[i], bx[j], sz[d], az[i], bz[j]);
            end
            r = mag(kk - known);
            if (r >= res_limit) continue;
            if (multi) push_created(d, est, n);
            else if (!found || r < best) begin
              found = 1; best = r; best_est = est;
            end
          end
        end
        if (!multi && found) push_created(d, best_est, n);
      end
      e = '0;
      e.kind = KIND_STATUS;
      e.dropped = lost;
      e.no_ref = (az.size() == 0 || bz.size() == 0);
      e.last = 1;
      expq.insert(expq.size(), e);
      ax.delete(); ay.delete(); az.delete(); bx.delete(); by.delete(); bz.delete();
      sx.delete(); sy.delete(); sz.delete(); sid.delete();
      lost = 0;
    endfunction

    function void note_item(logic op, logic [5:0] s, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
      longint lx, ly, lz;
      if (op == OP_END) begin
        close_event();
        return;
      end
      lx = $signed(x); ly = $signed(y); lz = $signed(z);
      if (s == plane_a) begin
        if (az.size() < StoreDepth) begin
          ax.insert(ax.size(), lx); ay.insert(ay.size(), ly); az.insert(az.size(), lz);
        end else lost = 1;
      end
      if (s == plane_b) begin
        if (bz.size() < StoreDepth) begin
          bx.insert(bx.size(), lx); by.insert(by.size(), ly); bz.insert(bz.size(), lz);
        end else lost = 1;
      end
      if (strip_mask[s]) begin
        if (sz.size() < StoreDepth) begin
          sid.insert(sid.size(), s); sx.insert(sx.size(), lx);
          sy.insert(sy.size(), ly); sz.insert(sz.size(), lz);
        end else lost = 1;
        return;
      end
      expq.insert(expq.size(), '{KIND_PASS, s, x, y, z, 1'b0, 1'b0, 1'b1});
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(hit_out_t act);
      hit_out_t e;
      if (expq.size() == 0) begin
        $error("unexpected output item: kind %0d sensor %0d", act.kind, act.sensor);
        errors++;
        return;
      end
      e = expq.pop_front();
      cmp("kind", e.kind, act.kind);
      cmp("out_sensor", e.sensor, act.sensor);
      cmp("out_x", e.x, act.x);
      cmp("out_y", e.y, act.y);
      cmp("out_z", e.z, act.z);
      cmp("hits_dropped", e.dropped, act.dropped);
      cmp("no_reference", e.no_ref, act.no_ref);
      cmp("last", e.last, act.last);
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_valid = 0;
  logic         s_ready;
  logic [103:0] s_data = '0;
  logic         s_user = OP_HIT;
  logic         m_valid;
  logic         m_ready = 0;
  logic [103:0] m_data;
  logic [1:0]   m_user;
  logic         m_last;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [63:0]  cfg_data = '0;

  track_scoreboard sb = new();
  int  send_idle = 0;
  int  recv_idle = 0;
  bit  hold_go = 0;
  bit  hold_seen = 0;
  int  hold_left = 0;
  int  cycles = 0;
  bit [5:0] strip_ids[3];

  always #2 clk_i = ~clk_i;

  missing_coordinate_line_estimator_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data)
  );

  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready = 0;
    end else begin
      m_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    hit_out_t r;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_ni && m_valid && m_ready) begin
      r = '{m_user, m_data[5:0], m_data[37:6], m_data[69:38], m_data[101:70],
            m_data[102], m_data[103], m_last};
      sb.check_result(r);
    end
  end

  task automatic send(logic op, logic [5:0] s, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z);
    while ($urandom_range(99) < send_idle) begin
      s_valid = 0;
      @(negedge clk_i);
    end
    s_valid = 1;
    s_user = op;
    s_data = {2'b00, z, y, x, s};
    do @(posedge clk_i); while (!s_ready);
    sb.note_item(op, s, x, y, z);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    s_valid = 0;
    cfg_we = 1; cfg_addr = idx; cfg_data = v;
    @(negedge clk_i);
    cfg_we = 0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    s_valid = 0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic end_event();
    send(OP_END, 6'($urandom), $urandom, $urandom, $urandom);
  endtask

  function automatic bit [5:0] free_sensor();
    bit [5:0] s;
    do s = 6'($urandom);
    while (s == sb.plane_a || s == sb.plane_b || sb.strip_mask[s]);
    return s;
  endfunction

  task automatic random_config();
    bit [63:0] mask;
    write_reg(REG_REF_A, $urandom_range(63));
    write_reg(REG_REF_B, ($urandom_range(9) == 0) ? sb.plane_a : 6'($urandom));
    mask = 0;
    foreach (strip_ids[k]) begin
      strip_ids[k] = 6'($urandom);
      mask[strip_ids[k]] = 1;
    end
    write_reg(REG_DUT_MASK, mask);
    write_reg(REG_AXIS, $urandom_range(1));
    write_reg(REG_MAX_RES, $urandom_range(1000, 30000));
    write_reg(REG_MULTI, $urandom_range(1));
  endtask

  // One event of hits spread around a straight track, in shuffled order.
  task automatic track_event(int na, int nb, int nd, int np);
    logic [5:0]  qs[$];
    int          qx[$], qy[$], qz[$];
    int          x0, y0, kx, ky, z, j, t;
    logic [5:0]  ts;
    x0 = $urandom_range(200000) - 100000;
    y0 = $urandom_range(200000) - 100000;
    kx = $urandom_range(1024) - 512;
    ky = $urandom_range(1024) - 512;
    for (int i = 0; i < na + nb + nd + np; i++) begin
      if (i < na) begin
        ts = sb.plane_a; z = -40000 + $urandom_range(20000);
      end else if (i < na + nb) begin
        ts = sb.plane_b; z = 20000 + $urandom_range(20000);
      end else if (i < na + nb + nd) begin
        ts = strip_ids[$urandom_range(2)]; z = $urandom_range(60000) - 30000;
      end else begin
        ts = free_sensor(); z = $urandom_range(80000) - 40000;
      end
      qs.insert(qs.size(), ts);
      qz.insert(qz.size(), z);
      qx.insert(qx.size(), x0 + kx * z / 1024 + int'($urandom_range(6000)) - 3000);
      qy.insert(qy.size(), y0 + ky * z / 1024 + int'($urandom_range(6000)) - 3000);
    end
    for (int i = qs.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      ts = qs[i]; qs[i] = qs[j]; qs[j] = ts;
      t = qx[i]; qx[i] = qx[j]; qx[j] = t;
      t = qy[i]; qy[i] = qy[j]; qy[j] = t;
      t = qz[i]; qz[i] = qz[j]; qz[j] = t;
    end
    foreach (qs[i]) send(OP_HIT, qs[i], qx[i], qy[i], qz[i]);
    end_event();
  endtask

  task automatic random_phase(int items);
    int start;
    start = 0;
    random_config();
    while (start < items) begin
      if ($urandom_range(9) == 0) begin
        // raw noise: full-range fields on any sensor
        for (int i = 0; i < 4; i++)
          send(OP_HIT, 6'($urandom), $urandom, $urandom, $urandom);
        end_event();
        start += 5;
      end else begin
        int na, nb, nd, np;
        na = $urandom_range(3); nb = $urandom_range(3);
        nd = $urandom_range(3); np = $urandom_range(3);
        track_event(na, nb, nd, np);
        start += na + nb + nd + np + 1;
      end
      if ($urandom_range(5) == 0) begin
        drain();
        random_config();
      end
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // reset settings: pass-through extremes, one ref-a hit, no ref-b
    send(OP_HIT, 6'd63, 32'h7fffffff, 32'h80000000, 32'h0);
    send(OP_HIT, 6'd0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send(OP_END, 6'h3f, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    drain();

    // huge quotient, saturated estimate, equal-z pair skipped
    write_reg(REG_DUT_MASK, 64'h8000_0000_0000_0020);
    write_reg(REG_MAX_RES, 31'h7fffffff);
    write_reg(REG_AXIS, 1);
    send(OP_HIT, 6'd0, 0, 0, 0);
    send(OP_HIT, 6'd1, 0, 32'h7fffffff, 0);
    send(OP_HIT, 6'd1, 0, 32'h7fffffff, 1);
    send(OP_HIT, 6'd63, 0, 5, 32'h7fffffff);
    end_event();
    drain();

    // shared ref id: store overflow and more created hits than allowed
    write_reg(REG_REF_A, 7);
    write_reg(REG_REF_B, 7);
    write_reg(REG_AXIS, 0);
    for (int k = 0; k < 9; k++) send(OP_HIT, 6'd7, k * 100, -k * 50, k * 1000);
    send(OP_HIT, 6'd5, 450, -225, 4500);
    send(OP_HIT, 6'd63, 900, -450, 9000);
    end_event();
    drain();

    // closest-pair mode with a tie on the first two pairs
    write_reg(REG_MULTI, 0);
    write_reg(REG_MAX_RES, 0);
    write_reg(REG_REF_B, 9);
    write_reg(REG_MAX_RES, 2000);
    send(OP_HIT, 6'd7, 0, 0, 0);
    send(OP_HIT, 6'd7, 0, 0, 0);
    send(OP_HIT, 6'd9, 1000, 1000, 2000);
    send(OP_HIT, 6'd5, 7, 520, 1000);
    end_event();
    drain();

    send_idle = 26; recv_idle = 77;
    random_phase(85);
    send_idle = 77; recv_idle = 26;
    random_phase(85);
    send_idle = 0; recv_idle = 0;
    random_config();
    hold_go = ~hold_go;
    for (int i = 0; i < 30; i++) send(OP_HIT, free_sensor(), $urandom, $urandom, $urandom);
    end_event();
    drain();
    random_phase(50);

    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.expq.size() != 0) $error("%0d expected items never arrived", sb.expq.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mcle_pkg.sv
rtl/mcle_line.sv
rtl/missing_coordinate_line_estimator_core.sv
rtl/mcle_checker.sv
sim/tb_top.sv
